FILE: sv/sst_pkg.sv
// shared types, codes and character classes of the source tokenizer
`timescale 1ns / 1ps
package sst_pkg;

    // scanner modes, one-hot
    typedef enum logic [15:0] {
        M_IDLE   = 16'h0001,
        M_LCOMM  = 16'h0002,
        M_BCOMM  = 16'h0004,
        M_BSTAR  = 16'h0008,
        M_IDENT  = 16'h0010,
        M_IDOT   = 16'h0020,
        M_DEC    = 16'h0040,
        M_DDOT   = 16'h0080,
        M_HEX    = 16'h0100,
        M_FRAC   = 16'h0200,
        M_ESTART = 16'h0400,
        M_ESIGN  = 16'h0800,
        M_EXP    = 16'h1000,
        M_STR    = 16'h2000,
        M_SESC   = 16'h4000,
        M_PEND   = 16'h8000
    } t_mode;

    // token kinds
    localparam logic [4:0] K_END   = 5'd0;
    localparam logic [4:0] K_IDENT = 5'd1;
    localparam logic [4:0] K_TRUE  = 5'd2;
    localparam logic [4:0] K_FALSE = 5'd3;
    localparam logic [4:0] K_IF    = 5'd4;
    localparam logic [4:0] K_ELSE  = 5'd5;
    localparam logic [4:0] K_WHILE = 5'd6;
    localparam logic [4:0] K_INT   = 5'd7;
    localparam logic [4:0] K_HEX   = 5'd8;
    localparam logic [4:0] K_FLOAT = 5'd9;
    localparam logic [4:0] K_STR   = 5'd10;
    localparam logic [4:0] K_LPAR  = 5'd11;
    localparam logic [4:0] K_RPAR  = 5'd12;
    localparam logic [4:0] K_LBRC  = 5'd13;
    localparam logic [4:0] K_RBRC  = 5'd14;
    localparam logic [4:0] K_COMMA = 5'd15;
    localparam logic [4:0] K_SEMI  = 5'd16;
    localparam logic [4:0] K_OP    = 5'd17;
    localparam logic [4:0] K_ERR   = 5'd18;

    // error codes
    localparam logic [2:0] E_NONE  = 3'd0;
    localparam logic [2:0] E_HEX   = 3'd1;
    localparam logic [2:0] E_EXP   = 3'd2;
    localparam logic [2:0] E_STR   = 3'd3;
    localparam logic [2:0] E_CHAR  = 3'd4;

    // keyword spellings, last character in the low byte
    localparam logic [39:0] KW_TRUE  = 40'h0054525545;
    localparam logic [39:0] KW_FALSE = 40'h46414C5345;
    localparam logic [39:0] KW_IF    = 40'h0000006966;
    localparam logic [39:0] KW_ELSE  = 40'h00656C7365;
    localparam logic [39:0] KW_WHILE = 40'h7768696C65;

    // one result record, position fields at their widest
    typedef struct packed {
        logic [4:0]  kind;
        logic [4:0]  op;
        logic [31:0] line;
        logic [31:0] col;
        logic [31:0] off;
        logic [31:0] len;
        logic [31:0] val;
        logic [2:0]  err;
        logic        last;
    } t_res;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_ident(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == "_");
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (is_digit(b))
            r = {1'b1, 4'(b - "0")};
        else if ((b >= "a") && (b <= "f"))
            r = {1'b1, 4'(b - "a" + 8'd10)};
        else if ((b >= "A") && (b <= "F"))
            r = {1'b1, 4'(b - "A" + 8'd10)};
        return r;
    endfunction

    // single-character operator, {valid, code}
    function automatic logic [5:0] op_single(input logic [7:0] b);
        logic [5:0] r;
        case (b)
            "+": r = {1'b1, 5'd8};
            "-": r = {1'b1, 5'd9};
            "*": r = {1'b1, 5'd10};
            "/": r = {1'b1, 5'd11};
            "&": r = {1'b1, 5'd12};
            "|": r = {1'b1, 5'd13};
            "^": r = {1'b1, 5'd14};
            "<": r = {1'b1, 5'd15};
            ">": r = {1'b1, 5'd16};
            "=": r = {1'b1, 5'd17};
            "~": r = {1'b1, 5'd18};
            "!": r = {1'b1, 5'd19};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    // two-character operator, {valid, code}
    function automatic logic [5:0] op_pair(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] r;
        r = 6'd0;
        if (a == "<" && b == "<") r = {1'b1, 5'd0};
        else if (a == ">" && b == ">") r = {1'b1, 5'd1};
        else if (a == "&" && b == "&") r = {1'b1, 5'd2};
        else if (a == "|" && b == "|") r = {1'b1, 5'd3};
        else if (a == "=" && b == "=") r = {1'b1, 5'd4};
        else if (a == "!" && b == "=") r = {1'b1, 5'd5};
        else if (a == "<" && b == "=") r = {1'b1, 5'd6};
        else if (a == ">" && b == "=") r = {1'b1, 5'd7};
        return r;
    endfunction

    // identifier or keyword kind
    function automatic logic [4:0] kw_kind(input logic [39:0] kw, input logic [2:0] len,
                                           input logic dot);
        logic [4:0] k;
        k = K_IDENT;
        if (!dot) begin
            if (len == 3'd4 && kw == KW_TRUE) k = K_TRUE;
            else if (len == 3'd5 && kw == KW_FALSE) k = K_FALSE;
            else if (len == 3'd2 && kw == KW_IF) k = K_IF;
            else if (len == 3'd4 && kw == KW_ELSE) k = K_ELSE;
            else if (len == 3'd5 && kw == KW_WHILE) k = K_WHILE;
        end
        return k;
    endfunction

    function automatic t_res mk(input logic [4:0] kind, input logic [4:0] op,
                                input logic [31:0] line, input logic [31:0] col,
                                input logic [31:0] off, input logic [31:0] len,
                                input logic [31:0] val, input logic [2:0] err);
        t_res r;
        r.kind = kind;
        r.op   = op;
        r.line = line;
        r.col  = col;
        r.off  = off;
        r.len  = len;
        r.val  = val;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

FILE: sv/sst_scan.sv
// scanner state registers and per-byte next-state and token logic
`timescale 1ns / 1ps
module sst_scan #(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_byte,
    input  logic                  i_end,
    output sst_pkg::t_res [1:0]   o_res,
    output logic [1:0]            o_cnt
);

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;

    sst_pkg::t_mode           r_mode, n_mode;
    logic [7:0]               r_held, n_held;
    logic                     r_held_v, n_held_v;
    logic [LINE_BITS-1:0]     r_cur_line, n_cur_line, r_cur_col, n_cur_col;
    logic [OFFSET_BITS-1:0]   r_cur_off, n_cur_off;
    logic [LINE_BITS-1:0]     r_tok_line, n_tok_line, r_tok_col, n_tok_col;
    logic [OFFSET_BITS-1:0]   r_tok_off, n_tok_off;
    logic [31:0]              r_acc, n_acc;
    logic [39:0]              r_kw, n_kw;
    logic [2:0]               r_len, n_len;
    logic                     r_dot, n_dot;
    logic                     r_halted, n_halted;

    sst_pkg::t_res [1:0]      res;
    logic [1:0]               cnt;
    logic                     do_start;
    logic [7:0]               b;
    logic [4:0]               hv;
    logic [5:0]               op;
    logic [OFFSET_BITS-1:0]   d0, dm, dp;
    logic [31:0]              dot_col, dot_off;

    // token spans, before and after a trailing character
    always_comb begin
        d0 = r_cur_off - r_tok_off;
        dm = (d0 == '0) ? d0 : d0 - 1'b1;
        dp = (d0 == OFF_MAX) ? d0 : d0 + 1'b1;
        dot_col = 32'((r_cur_col > LINE_BITS'(1)) ? r_cur_col - 1'b1 : LINE_BITS'(1));
        dot_off = 32'((r_cur_off > '0) ? r_cur_off - 1'b1 : r_cur_off);
    end

    // next state and results for the byte in transfer
    always_comb begin
        n_mode = r_mode; n_held = r_held; n_held_v = r_held_v;
        n_cur_line = r_cur_line; n_cur_col = r_cur_col; n_cur_off = r_cur_off;
        n_tok_line = r_tok_line; n_tok_col = r_tok_col; n_tok_off = r_tok_off;
        n_acc = r_acc; n_kw = r_kw; n_len = r_len; n_dot = r_dot; n_halted = r_halted;
        res = '0;
        cnt = 2'd0;
        do_start = 1'b0;
        b = i_byte;
        hv = sst_pkg::hex_val(b);
        op = 6'd0;
        if (i_take) begin
            if (i_end) begin
                // flush the open token, then the end token unless the scan has halted on an error
                if (!r_halted) begin
                    case (r_mode)
                        sst_pkg::M_IDENT: begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::kw_kind(r_kw, r_len, r_dot),
                                5'd0, 32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                32'(d0), 32'd0, sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                        end
                        sst_pkg::M_IDOT: begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::kw_kind(r_kw, r_len, r_dot),
                                5'd0, 32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                32'(dm), 32'd0, sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_ERR, 5'd0, 32'(r_cur_line),
                                dot_col, dot_off, 32'd1, 32'd0, sst_pkg::E_CHAR);
                            cnt = cnt + 2'd1;
                            n_halted = 1'b1;
                        end
                        sst_pkg::M_DEC: begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_INT, 5'd0, 32'(r_tok_line),
                                32'(r_tok_col), 32'(r_tok_off), 32'(d0), r_acc,
                                sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                        end
                        sst_pkg::M_DDOT: begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_INT, 5'd0, 32'(r_tok_line),
                                32'(r_tok_col), 32'(r_tok_off), 32'(dm), r_acc,
                                sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_ERR, 5'd0, 32'(r_cur_line),
                                dot_col, dot_off, 32'd1, 32'd0, sst_pkg::E_CHAR);
                            cnt = cnt + 2'd1;
                            n_halted = 1'b1;
                        end
                        sst_pkg::M_HEX: begin
                            if (r_len == 3'd0) begin
                                res[cnt[0]] = sst_pkg::mk(sst_pkg::K_ERR, 5'd0,
                                    32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                    32'(d0), 32'd0, sst_pkg::E_HEX);
                                n_halted = 1'b1;
                            end else begin
                                res[cnt[0]] = sst_pkg::mk(sst_pkg::K_HEX, 5'd0,
                                    32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                    32'(d0), r_acc, sst_pkg::E_NONE);
                            end
                            cnt = cnt + 2'd1;
                        end
                        sst_pkg::M_FRAC, sst_pkg::M_EXP: begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_FLOAT, 5'd0,
                                32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                32'(d0), 32'd0, sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                        end
                        sst_pkg::M_ESTART, sst_pkg::M_ESIGN: begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_ERR, 5'd0,
                                32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                32'(d0), 32'd0, sst_pkg::E_EXP);
                            cnt = cnt + 2'd1;
                            n_halted = 1'b1;
                        end
                        sst_pkg::M_STR, sst_pkg::M_SESC: begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_ERR, 5'd0,
                                32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                32'(d0), 32'd0, sst_pkg::E_STR);
                            cnt = cnt + 2'd1;
                            n_halted = 1'b1;
                        end
                        sst_pkg::M_PEND: begin
                            if (r_held_v) begin
                                op = sst_pkg::op_single(r_held);
                                res[cnt[0]] = sst_pkg::mk(sst_pkg::K_OP, op[4:0],
                                    32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                    32'd1, 32'd0, sst_pkg::E_NONE);
                                cnt = cnt + 2'd1;
                            end
                        end
                        default: ;
                    endcase
                    if (!n_halted) begin
                        res[cnt[0]] = sst_pkg::mk(sst_pkg::K_END, 5'd0, 32'(r_cur_line),
                            32'(r_cur_col), 32'(r_cur_off), 32'd0, 32'd0, sst_pkg::E_NONE);
                        cnt = cnt + 2'd1;
                    end
                end
                // back to the reset state for the next source
                n_mode = sst_pkg::M_IDLE; n_held = 8'd0; n_held_v = 1'b0;
                n_cur_line = LINE_BITS'(1); n_cur_col = LINE_BITS'(1); n_cur_off = '0;
                n_tok_line = LINE_BITS'(1); n_tok_col = LINE_BITS'(1); n_tok_off = '0;
                n_acc = '0; n_kw = '0; n_len = '0; n_dot = 1'b0; n_halted = 1'b0;
            end else if (!r_halted) begin
                case (r_mode)
                    sst_pkg::M_LCOMM: if (b == "\n") n_mode = sst_pkg::M_IDLE;
                    sst_pkg::M_BCOMM: if (b == "*") n_mode = sst_pkg::M_BSTAR;
                    sst_pkg::M_BSTAR: begin
                        if (b == "/") n_mode = sst_pkg::M_IDLE;
                        else if (b == "*") n_mode = sst_pkg::M_BSTAR;
                        else n_mode = sst_pkg::M_BCOMM;
                    end
                    sst_pkg::M_IDENT, sst_pkg::M_IDOT: begin
                        if (sst_pkg::is_ident(b)) begin
                            if (r_mode == sst_pkg::M_IDOT) n_dot = 1'b1;
                            n_kw = {r_kw[31:0], b};
                            if (r_len < 3'd7) n_len = r_len + 3'd1;
                            n_mode = sst_pkg::M_IDENT;
                        end else if (r_mode == sst_pkg::M_IDENT && b == ".") begin
                            n_mode = sst_pkg::M_IDOT;
                        end else if (r_mode == sst_pkg::M_IDENT) begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::kw_kind(r_kw, r_len, r_dot),
                                5'd0, 32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                32'(d0), 32'd0, sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            do_start = 1'b1;
                        end else begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::kw_kind(r_kw, r_len, r_dot),
                                5'd0, 32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                32'(dm), 32'd0, sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_ERR, 5'd0, 32'(r_cur_line),
                                dot_col, dot_off, 32'd1, 32'd0, sst_pkg::E_CHAR);
                            cnt = cnt + 2'd1;
                            n_halted = 1'b1;
                        end
                    end
                    sst_pkg::M_DEC: begin
                        if (sst_pkg::is_digit(b)) begin
                            n_acc = {r_acc[28:0], 3'd0} + {r_acc[30:0], 1'b0}
                                    + 32'(b - "0");
                            if (r_len < 3'd7) n_len = r_len + 3'd1;
                        end else if ((b == "x" || b == "X") && r_len == 3'd1
                                     && r_acc == 32'd0) begin
                            n_len = 3'd0;
                            n_mode = sst_pkg::M_HEX;
                        end else if (b == ".") begin
                            n_mode = sst_pkg::M_DDOT;
                        end else if (b == "e" || b == "E") begin
                            n_mode = sst_pkg::M_ESTART;
                        end else begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_INT, 5'd0, 32'(r_tok_line),
                                32'(r_tok_col), 32'(r_tok_off), 32'(d0), r_acc,
                                sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    sst_pkg::M_DDOT: begin
                        if (sst_pkg::is_digit(b)) begin
                            n_mode = sst_pkg::M_FRAC;
                        end else begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_INT, 5'd0, 32'(r_tok_line),
                                32'(r_tok_col), 32'(r_tok_off), 32'(dm), r_acc,
                                sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_ERR, 5'd0, 32'(r_cur_line),
                                dot_col, dot_off, 32'd1, 32'd0, sst_pkg::E_CHAR);
                            cnt = cnt + 2'd1;
                            n_halted = 1'b1;
                        end
                    end
                    sst_pkg::M_HEX: begin
                        if (hv[4]) begin
                            n_acc = {r_acc[27:0], hv[3:0]};
                            if (r_len < 3'd7) n_len = r_len + 3'd1;
                        end else if (r_len == 3'd0) begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_ERR, 5'd0, 32'(r_tok_line),
                                32'(r_tok_col), 32'(r_tok_off), 32'(d0), 32'd0,
                                sst_pkg::E_HEX);
                            cnt = cnt + 2'd1;
                            n_halted = 1'b1;
                        end else begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_HEX, 5'd0, 32'(r_tok_line),
                                32'(r_tok_col), 32'(r_tok_off), 32'(d0), r_acc,
                                sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    sst_pkg::M_FRAC, sst_pkg::M_EXP: begin
                        if (r_mode == sst_pkg::M_FRAC && (b == "e" || b == "E")) begin
                            n_mode = sst_pkg::M_ESTART;
                        end else if (!sst_pkg::is_digit(b)) begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_FLOAT, 5'd0,
                                32'(r_tok_line), 32'(r_tok_col), 32'(r_tok_off),
                                32'(d0), 32'd0, sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    sst_pkg::M_ESTART, sst_pkg::M_ESIGN: begin
                        if (r_mode == sst_pkg::M_ESTART && (b == "+" || b == "-")) begin
                            n_mode = sst_pkg::M_ESIGN;
                        end else if (sst_pkg::is_digit(b)) begin
                            n_mode = sst_pkg::M_EXP;
                        end else begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_ERR, 5'd0, 32'(r_tok_line),
                                32'(r_tok_col), 32'(r_tok_off), 32'(d0), 32'd0,
                                sst_pkg::E_EXP);
                            cnt = cnt + 2'd1;
                            n_halted = 1'b1;
                        end
                    end
                    sst_pkg::M_STR: begin
                        if (b == "\"") begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_STR, 5'd0, 32'(r_tok_line),
                                32'(r_tok_col), 32'(r_tok_off), 32'(dp), 32'd0,
                                sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            n_mode = sst_pkg::M_IDLE;
                        end else if (b == "\\") begin
                            n_mode = sst_pkg::M_SESC;
                        end
                    end
                    sst_pkg::M_SESC: n_mode = sst_pkg::M_STR;
                    sst_pkg::M_PEND: begin
                        n_held_v = 1'b0;
                        op = sst_pkg::op_pair(r_held, b);
                        if (r_held == "/" && b == "/") begin
                            n_mode = sst_pkg::M_LCOMM;
                        end else if (r_held == "/" && b == "*") begin
                            n_mode = sst_pkg::M_BCOMM;
                        end else if (op[5]) begin
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_OP, op[4:0], 32'(r_tok_line),
                                32'(r_tok_col), 32'(r_tok_off), 32'd2, 32'd0,
                                sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            n_mode = sst_pkg::M_IDLE;
                        end else begin
                            op = sst_pkg::op_single(r_held);
                            res[cnt[0]] = sst_pkg::mk(sst_pkg::K_OP, op[4:0], 32'(r_tok_line),
                                32'(r_tok_col), 32'(r_tok_off), 32'd1, 32'd0,
                                sst_pkg::E_NONE);
                            cnt = cnt + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    default: do_start = 1'b1;
                endcase

                // a new token begins at this byte
                if (do_start) begin
                    n_tok_line = r_cur_line; n_tok_col = r_cur_col; n_tok_off = r_cur_off;
                    n_acc = '0; n_kw = '0; n_len = '0; n_dot = 1'b0; n_held_v = 1'b0;
                    n_mode = sst_pkg::M_IDLE;
                    op = sst_pkg::op_single(b);
                    if (b == " " || b == "\t" || b == "\r" || b == "\n") begin
                        n_mode = sst_pkg::M_IDLE;
                    end else if (sst_pkg::is_alpha(b) || b == "_") begin
                        n_kw = {32'd0, b};
                        n_len = 3'd1;
                        n_mode = sst_pkg::M_IDENT;
                    end else if (sst_pkg::is_digit(b)) begin
                        n_acc = 32'(b - "0");
                        n_len = 3'd1;
                        n_mode = sst_pkg::M_DEC;
                    end else if (b == "\"") begin
                        n_mode = sst_pkg::M_STR;
                    end else if (b == "<" || b == ">" || b == "&" || b == "|" || b == "="
                                 || b == "!" || b == "/") begin
                        n_held = b;
                        n_held_v = 1'b1;
                        n_mode = sst_pkg::M_PEND;
                    end else begin
                        res[cnt[0]] = sst_pkg::mk(sst_pkg::K_OP, op[4:0], 32'(r_cur_line),
                            32'(r_cur_col), 32'(r_cur_off), 32'd1, 32'd0, sst_pkg::E_NONE);
                        case (b)
                            "(": res[cnt[0]].kind = sst_pkg::K_LPAR;
                            ")": res[cnt[0]].kind = sst_pkg::K_RPAR;
                            "{": res[cnt[0]].kind = sst_pkg::K_LBRC;
                            "}": res[cnt[0]].kind = sst_pkg::K_RBRC;
                            ",": res[cnt[0]].kind = sst_pkg::K_COMMA;
                            ";": res[cnt[0]].kind = sst_pkg::K_SEMI;
                            default: begin
                                if (!op[5]) begin
                                    res[cnt[0]].kind = sst_pkg::K_ERR;
                                    res[cnt[0]].err  = sst_pkg::E_CHAR;
                                    n_halted = 1'b1;
                                end
                            end
                        endcase
                        if (res[cnt[0]].kind != sst_pkg::K_OP) res[cnt[0]].op = 5'd0;
                        cnt = cnt + 2'd1;
                    end
                end

                // position after this byte, saturating
                if (b == "\n") begin
                    if (r_cur_line != LINE_MAX) n_cur_line = r_cur_line + 1'b1;
                    n_cur_col = LINE_BITS'(1);
                end else if (r_cur_col != LINE_MAX) begin
                    n_cur_col = r_cur_col + 1'b1;
                end
                if (r_cur_off != OFF_MAX) n_cur_off = r_cur_off + 1'b1;
            end
            if (cnt != 2'd0) res[cnt[0] ^ 1'b1].last = 1'b1;
        end
    end

    assign o_res = res;
    assign o_cnt = cnt;

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sst_pkg::M_IDLE; r_held <= 8'd0; r_held_v <= 1'b0;
            r_cur_line <= LINE_BITS'(1); r_cur_col <= LINE_BITS'(1); r_cur_off <= '0;
            r_tok_line <= LINE_BITS'(1); r_tok_col <= LINE_BITS'(1); r_tok_off <= '0;
            r_acc <= '0; r_kw <= '0; r_len <= '0; r_dot <= 1'b0; r_halted <= 1'b0;
        end else begin
            r_mode <= n_mode; r_held <= n_held; r_held_v <= n_held_v;
            r_cur_line <= n_cur_line; r_cur_col <= n_cur_col; r_cur_off <= n_cur_off;
            r_tok_line <= n_tok_line; r_tok_col <= n_tok_col; r_tok_off <= n_tok_off;
            r_acc <= n_acc; r_kw <= n_kw; r_len <= n_len; r_dot <= n_dot;
            r_halted <= n_halted;
        end
    end

endmodule

FILE: sv/sst_fifo.sv
// four-entry result queue taking up to two results per cycle
`timescale 1ns / 1ps
module sst_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sst_pkg::t_res [1:0]   i_res,
    input  logic [1:0]            i_cnt,
    output logic                  o_room,
    output logic                  o_valid,
    output sst_pkg::t_res         o_res,
    input  logic                  i_ready
);

    localparam int DEPTH = 4;

    sst_pkg::t_res        r_mem [DEPTH];
    logic [1:0]           r_wp, r_rp;
    logic [2:0]           r_count, n_count;
    logic                 pop;

    assign o_valid = (r_count != 3'd0);
    assign o_res   = r_mem[r_rp];
    assign o_room  = (r_count <= 3'd2);
    assign pop     = o_valid && i_ready;
    assign n_count = r_count + 3'(i_cnt) - 3'(pop);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_cnt != 2'd0) r_mem[r_wp] <= i_res[0];
        if (i_cnt == 2'd2) r_mem[r_wp + 2'd1] <= i_res[1];
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 2'd0;
            r_rp <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wp <= r_wp + i_cnt;
            r_rp <= r_rp + 2'(pop);
            r_count <= n_count;
        end
    end

endmodule

FILE: sv/script_source_tokenizer_top.sv
// source tokenizer: byte stream in, one token per output transfer
// a token is registered in the result queue with the byte that completes it
// throughput: one byte per cycle while the four-entry result queue has room for two
// results; the queue drains one token per ready cycle, so two-token bytes slow intake
// reset: synchronous active low, clears scanner state, positions and the queue
`timescale 1ns / 1ps
module script_source_tokenizer_top #(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // src_byte
    input  logic                  i_s_tuser,   // end_of_source
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [((45 + 2 * LINE_BITS + 2 * OFFSET_BITS + 7) / 8) * 8 - 1:0] o_m_tdata,
                                               // token_kind, op_code, start_line, start_col,
                                               // start_offset, byte_length, int_value,
                                               // error_code, zero fill
    output logic                  o_m_tlast    // last_of_run
);

    localparam int FIELD_W = 45 + 2 * LINE_BITS + 2 * OFFSET_BITS;
    localparam int DATA_W  = ((FIELD_W + 7) / 8) * 8;

    sst_pkg::t_res [1:0]  scan_res;
    logic [1:0]           scan_cnt;
    sst_pkg::t_res        q_res;
    logic                 take;

    assign take = i_s_tvalid && o_s_tready;

    sst_scan #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_s_tdata),
        .i_end   (i_s_tuser),
        .o_res   (scan_res),
        .o_cnt   (scan_cnt)
    );

    sst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (scan_res),
        .i_cnt   (scan_cnt),
        .o_room  (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_res   (q_res),
        .i_ready (i_m_tready)
    );

    // pack the result fields, first field lowest
    assign o_m_tdata = {(DATA_W - FIELD_W)'(0), q_res.err, q_res.val,
                        q_res.len[OFFSET_BITS-1:0], q_res.off[OFFSET_BITS-1:0],
                        q_res.col[LINE_BITS-1:0], q_res.line[LINE_BITS-1:0],
                        q_res.op, q_res.kind};
    assign o_m_tlast = q_res.last;

endmodule

FILE: sv/sst_chk.sv
// port-level checks on the tokenizer output stream
`timescale 1ns / 1ps
module sst_chk #(
    parameter int DATA_W = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  logic [DATA_W-1:0] o_m_tdata,
    input  logic              o_m_tlast
);

    // no result straight after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result shown right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("stalled result changed");

    // the end token always closes its run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[4:0] == sst_pkg::K_END |-> o_m_tlast)
        else $error("end token without tlast");

    // operator code only on operator tokens
    a_op_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[4:0] != sst_pkg::K_OP |-> o_m_tdata[9:5] == 5'd0)
        else $error("operator code on non-operator token");

endmodule

bind script_source_tokenizer_top sst_chk #(.DATA_W(DATA_W)) u_sst_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
